FILE: src/agbk_pkg.sv
// ----------------------------------------------------------------------------
// agbk_pkg
// shared types, constants and saturation helpers of the angle/bias filter
// ----------------------------------------------------------------------------
package agbk_pkg;

  localparam int unsigned MdW = 49;   // operand width of the mul/div unit
  localparam int unsigned PrW = 2 * MdW;

  localparam logic [31:0] QAngleRst = 32'd16777;
  localparam logic [31:0] QBiasRst  = 32'd50332;
  localparam logic [31:0] RMeasRst  = 32'd503316;

  localparam logic signed [33:0] HalfTurn = 34'sd11796480;
  localparam logic signed [33:0] FullTurn = 34'sd23592960;
  localparam logic [MdW-1:0]     MsPerS   = MdW'(1000);

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R_MEAS  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] q_angle;
    logic [31:0] q_bias;
    logic [31:0] meas_var;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    else if (x < -66'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
    if (x > 66'sd140737488355327) return 48'sh7fffffffffff;
    else if (x < -66'sd140737488355328) return 48'sh800000000000;
    else return x[47:0];
  endfunction

endpackage

FILE: src/agbk_if.sv
// ----------------------------------------------------------------------------
// agbk channel interfaces
// valid/ready channels for samples and filtered angles
// ----------------------------------------------------------------------------
interface agbk_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  logic [15:0]        elapsed_ms;
  modport source (output valid, measured_angle, gyro_rate, elapsed_ms, input ready);
  modport sink (input valid, measured_angle, gyro_rate, elapsed_ms, output ready);
endinterface

interface agbk_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] filtered_angle;
  modport source (output valid, filtered_angle, input ready);
  modport sink (input valid, filtered_angle, output ready);
endinterface

FILE: src/agbk_cfg.sv
// ----------------------------------------------------------------------------
// agbk_cfg
// apb register bank for the noise settings
// ----------------------------------------------------------------------------
module agbk_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output agbk_pkg::cfg_t     cfg
);

  agbk_pkg::cfg_t     regs_r;
  agbk_pkg::reg_idx_t idx;

  assign idx = agbk_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.q_angle  <= agbk_pkg::QAngleRst;
      regs_r.q_bias   <= agbk_pkg::QBiasRst;
      regs_r.meas_var <= agbk_pkg::RMeasRst;
    end else if (psel && penable && pwrite) begin
      case (idx)
        agbk_pkg::REG_Q_ANGLE: regs_r.q_angle <= pwdata;
        agbk_pkg::REG_Q_BIAS:  regs_r.q_bias <= pwdata;
        agbk_pkg::REG_R_MEAS:  regs_r.meas_var <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      agbk_pkg::REG_Q_ANGLE: prdata = regs_r.q_angle;
      agbk_pkg::REG_Q_BIAS:  prdata = regs_r.q_bias;
      agbk_pkg::REG_R_MEAS:  prdata = regs_r.meas_var;
      default:               prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/agbk_muldiv.sv
// ----------------------------------------------------------------------------
// agbk_muldiv
// bit-serial round(a*b/c): shift-add multiply, then restoring divide
// ----------------------------------------------------------------------------
module agbk_muldiv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [agbk_pkg::MdW-1:0]   a,
  input  logic signed [agbk_pkg::MdW-1:0]   b,
  input  logic [agbk_pkg::MdW-1:0]          c,
  output logic                              done,
  output logic signed [63:0]                res
);

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_RND, M_DIV, M_DONE} mstate_t;

  mstate_t                  st_r;
  logic [6:0]               cnt_r;
  logic [agbk_pkg::MdW-1:0] mc_r;
  logic [agbk_pkg::MdW-1:0] dv_r;
  logic [agbk_pkg::PrW-1:0] prod_r;
  logic [agbk_pkg::MdW:0]   rem_r;
  logic [61:0]              q_r;
  logic                     over_r;
  logic                     neg_r;

  logic [agbk_pkg::MdW:0]   hi_sum;
  logic [agbk_pkg::MdW:0]   rem_sh;
  logic                     ge;
  logic [63:0]              qv;

  assign hi_sum = {1'b0, prod_r[agbk_pkg::PrW-1:agbk_pkg::MdW]} + {1'b0, mc_r};
  assign rem_sh = {rem_r[agbk_pkg::MdW-1:0], prod_r[agbk_pkg::PrW-1]};
  assign ge     = rem_sh >= {1'b0, dv_r};
  assign qv     = over_r ? 64'h4000_0000_0000_0000 : {2'b00, q_r};
  assign res    = neg_r ? -$signed(qv) : $signed(qv);
  assign done   = (st_r == M_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
    end else begin
      case (st_r)
        M_IDLE: begin
          if (start) begin
            mc_r   <= a[agbk_pkg::MdW-1] ? agbk_pkg::MdW'(-a) : a;
            prod_r <= {{agbk_pkg::MdW{1'b0}}, (b[agbk_pkg::MdW-1] ? agbk_pkg::MdW'(-b) : b)};
            dv_r   <= c;
            neg_r  <= a[agbk_pkg::MdW-1] != b[agbk_pkg::MdW-1];
            cnt_r  <= 7'd0;
            st_r   <= M_MUL;
          end
        end
        M_MUL: begin
          if (prod_r[0]) begin
            prod_r <= {hi_sum, prod_r[agbk_pkg::MdW-1:1]};
          end else begin
            prod_r <= prod_r >> 1;
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(agbk_pkg::MdW - 1)) begin
            st_r <= M_RND;
          end
        end
        M_RND: begin
          // rounding: add half the divisor before truncating division
          prod_r <= prod_r + agbk_pkg::PrW'(dv_r >> 1);
          rem_r  <= '0;
          q_r    <= '0;
          over_r <= 1'b0;
          cnt_r  <= 7'(agbk_pkg::PrW - 1);
          st_r   <= M_DIV;
        end
        M_DIV: begin
          rem_r  <= ge ? rem_sh - {1'b0, dv_r} : rem_sh;
          prod_r <= prod_r << 1;
          q_r    <= {q_r[60:0], ge};
          // quotient bits at 2^62 and above cap the magnitude
          if (ge && cnt_r >= 7'd62) begin
            over_r <= 1'b1;
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            st_r <= M_DONE;
          end
        end
        M_DONE: st_r <= M_IDLE;
        default: st_r <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: src/angle_gyro_bias_kalman.sv
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman
// two-state kalman filter fusing absolute angle and gyro rate (angle, bias)
// ----------------------------------------------------------------------------
// sequence: ten mul/div passes and two wrap checks from input transaction to out
//   valid, each wrap check stepping one 360-degree turn at a time, up to 182 steps
//   on the innovation and 91 on the angle; the gain passes drop out when it is skipped
// throughput: one transaction at a time, next accepted the cycle after the result
//   is registered; the single mul/div unit and output back-pressure set the pace
// reset (rst_n, synchronous): state cleared, noise registers to defaults, idle
module angle_gyro_bias_kalman (
  input  logic        clk,
  input  logic        rst_n,
  agbk_in_if.sink     in_ch,
  agbk_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // sequencer states
  typedef enum logic [2:0] {T_IDLE, T_START, T_WAIT, T_WRAP} tstate_t;

  // mul/div passes in order: prediction first, then the gain corrections
  typedef enum logic [3:0] {
    OP_ANG, OP_P11, OP_INNER, OP_QB, OP_KANG, OP_KBIAS, OP_C0, OP_C1, OP_C2, OP_C3
  } op_t;

  agbk_pkg::cfg_t cfg;

  tstate_t            st_r;
  op_t                op_r;
  logic signed [31:0] meas_r, gyro_r;
  logic [15:0]        ms_r;
  logic signed [31:0] ae_r, bias_r, ang_r;
  logic signed [47:0] cov_r [4];
  logic signed [47:0] n00_r, n01_r, n10_r, n11_r;
  logic signed [48:0] s_r;
  logic signed [33:0] y_r, wx_r;
  logic               wsel_r;     // wrap target: 0 innovation, 1 angle
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [24:0] out_data_r;

  // shared mul/div unit
  logic                              md_start, md_done;
  logic signed [agbk_pkg::MdW-1:0]   md_a, md_b;
  logic [agbk_pkg::MdW-1:0]          md_c;
  logic signed [63:0]                md_res;

  logic signed [65:0] r66, qa66, qb66, rm66;
  logic signed [47:0] nsub;
  logic signed [31:0] ang_base;
  logic               out_free;
  logic               wrap_in;
  logic               out_load;

  agbk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  agbk_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .done  (md_done),
    .res   (md_res)
  );

  assign cfg_pready = 1'b1;
  assign in_ch.ready = (st_r == T_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.filtered_angle = out_data_r;
  assign md_start = (st_r == T_START);
  assign out_free = !out_valid_r || out_ch.ready;

  // final angle inside +-180 and the output register can take it
  assign wrap_in  = (wx_r <= agbk_pkg::HalfTurn) && (wx_r >= -agbk_pkg::HalfTurn);
  assign out_load = (st_r == T_WRAP) && wsel_r && wrap_in && out_free;
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  // noise settings widened from q8.24 to q16.32
  assign qa66 = $signed({26'd0, cfg.q_angle, 8'd0});
  assign qb66 = $signed({26'd0, cfg.q_bias, 8'd0});
  assign rm66 = $signed({26'd0, cfg.meas_var, 8'd0});
  assign r66  = 66'(md_res);

  // operand selection per pass
  always_comb begin
    md_a = '0;
    md_b = agbk_pkg::MdW'(ms_r);
    md_c = agbk_pkg::MsPerS;
    nsub = n00_r;
    case (op_r)
      OP_ANG:   md_a = agbk_pkg::MdW'(34'(gyro_r) - 34'(bias_r));
      OP_P11:   md_a = agbk_pkg::MdW'(cov_r[3]);
      OP_INNER: md_a = agbk_pkg::MdW'(n00_r);   // holds inner term here
      OP_QB:    md_a = agbk_pkg::MdW'(qb66);
      OP_KANG: begin
        md_a = agbk_pkg::MdW'(n00_r);
        md_b = agbk_pkg::MdW'(y_r);
        md_c = s_r[agbk_pkg::MdW-1:0];
      end
      OP_KBIAS: begin
        md_a = agbk_pkg::MdW'(n10_r);
        md_b = agbk_pkg::MdW'(y_r);
        md_c = s_r[agbk_pkg::MdW-1:0];
      end
      OP_C0: begin
        md_a = agbk_pkg::MdW'(n00_r);
        md_b = agbk_pkg::MdW'(n00_r);
        md_c = s_r[agbk_pkg::MdW-1:0];
        nsub = n00_r;
      end
      OP_C1: begin
        md_a = agbk_pkg::MdW'(n00_r);
        md_b = agbk_pkg::MdW'(n01_r);
        md_c = s_r[agbk_pkg::MdW-1:0];
        nsub = n01_r;
      end
      OP_C2: begin
        md_a = agbk_pkg::MdW'(n10_r);
        md_b = agbk_pkg::MdW'(n00_r);
        md_c = s_r[agbk_pkg::MdW-1:0];
        nsub = n10_r;
      end
      OP_C3: begin
        md_a = agbk_pkg::MdW'(n10_r);
        md_b = agbk_pkg::MdW'(n01_r);
        md_c = s_r[agbk_pkg::MdW-1:0];
        nsub = n11_r;
      end
      default: ;
    endcase
  end

  assign ang_base = (op_r == OP_ANG) ? ae_r : ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      op_r        <= OP_ANG;
      wsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ae_r        <= '0;
      bias_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        cov_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      case (st_r)
        T_IDLE: begin
          if (in_ch.valid) begin
            meas_r <= in_ch.measured_angle;
            gyro_r <= in_ch.gyro_rate;
            ms_r   <= in_ch.elapsed_ms;
            op_r   <= OP_ANG;
            st_r   <= T_START;
          end
        end
        T_START: st_r <= T_WAIT;
        T_WAIT: begin
          if (md_done) begin
            // end of prediction and last correction go to a wrap
            st_r <= (op_r == OP_QB || op_r == OP_C3) ? T_WRAP : T_START;
            op_r <= op_t'(op_r + 4'd1);
            case (op_r)
              OP_ANG: ang_r <= agbk_pkg::sat32(66'(ang_base) + r66);
              OP_P11: begin
                // inner term parked in n00 until its own pass
                n00_r <= agbk_pkg::sat48(r66 - 66'(cov_r[1]) - 66'(cov_r[2]) + qa66);
                n01_r <= agbk_pkg::sat48(66'(cov_r[1]) - r66);
                n10_r <= agbk_pkg::sat48(66'(cov_r[2]) - r66);
              end
              OP_INNER: n00_r <= agbk_pkg::sat48(66'(cov_r[0]) + r66);
              OP_QB: begin
                n11_r  <= agbk_pkg::sat48(66'(cov_r[3]) + r66);
                s_r    <= 49'(n00_r) + 49'(rm66);
                wx_r   <= 34'(meas_r) - 34'(ang_r);
                wsel_r <= 1'b0;
              end
              OP_KANG:  ang_r <= agbk_pkg::sat32(66'(ang_base) + r66);
              OP_KBIAS: bias_r <= agbk_pkg::sat32(66'(bias_r) + r66);
              OP_C0:    cov_r[0] <= agbk_pkg::sat48(66'(nsub) - r66);
              OP_C1:    cov_r[1] <= agbk_pkg::sat48(66'(nsub) - r66);
              OP_C2:    cov_r[2] <= agbk_pkg::sat48(66'(nsub) - r66);
              OP_C3: begin
                cov_r[3] <= agbk_pkg::sat48(66'(nsub) - r66);
                wx_r     <= 34'(ang_r);
                wsel_r   <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        T_WRAP: begin
          // one full turn per cycle until within +-180
          if (wx_r > agbk_pkg::HalfTurn) begin
            wx_r <= wx_r - agbk_pkg::FullTurn;
          end else if (wx_r < -agbk_pkg::HalfTurn) begin
            wx_r <= wx_r + agbk_pkg::FullTurn;
          end else if (!wsel_r) begin
            y_r <= wx_r;
            if (s_r > 49'sd0) begin
              op_r <= OP_KANG;
              st_r <= T_START;
            end else begin
              // no usable gain: keep the prediction
              cov_r[0] <= n00_r;
              cov_r[1] <= n01_r;
              cov_r[2] <= n10_r;
              cov_r[3] <= n11_r;
              wx_r     <= 34'(ang_r);
              wsel_r   <= 1'b1;
            end
          end else if (out_free) begin
            ae_r        <= wx_r[31:0];
            out_data_r  <= wx_r[24:0];
            st_r        <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the angle/gyro-bias kalman filter: directed and
// random samples under several noise settings and handshake idling
// patterns, each filtered angle compared with a bit-exact predictor
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // a full sample step plus receiver stalls stays below the watchdog limit
  localparam int unsigned WatchdogLimit = 60000;
  localparam int unsigned DrainCycles   = 2500;
  localparam int unsigned RandomItems   = 1330;
  localparam longint HalfDeg = 180 * 65536;
  localparam longint FullDeg = 360 * 65536;

  // --------------------------------------------------------------------------
  // scoreboard: fixed-point filter copy and queue of filtered angles
  // --------------------------------------------------------------------------
  class kalman_scoreboard;
    longint unsigned noise_angle, noise_bias, noise_meas;
    longint angle_est, bias_est;
    longint cov[4];
    logic signed [24:0] angle_q[$];
    int errors;

    function new();
      noise_angle = agbk_pkg::QAngleRst;
      noise_bias  = agbk_pkg::QBiasRst;
      noise_meas  = agbk_pkg::RMeasRst;
      angle_est = 0;
      bias_est  = 0;
      foreach (cov[i]) cov[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(agbk_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        agbk_pkg::REG_Q_ANGLE: noise_angle = val;
        agbk_pkg::REG_Q_BIAS:  noise_bias  = val;
        agbk_pkg::REG_R_MEAS:  noise_meas  = val;
        default: ;
      endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint clip32(longint x);
      return clip(x, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    endfunction

    function longint clip48(longint x);
      return clip(x, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    endfunction

    // round(a*b/c), halves away from zero, magnitude capped at 2^62
    function longint scaled_quot(longint a, longint b, longint c);
      logic [127:0] prod, quot;
      logic [63:0] ua, ub;
      bit neg;
      longint q;
      if (c <= 0 || c >= (64'sd1 <<< 62)) return 0;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = prod + (c >> 1);
      quot = prod / c;
      if (quot >= (128'd1 << 62)) quot = 128'd1 << 62;
      q = quot[63:0];
      return neg ? -q : q;
    endfunction

    function longint wrap_angle(longint x);
      if (x > HalfDeg) x -= ((x - HalfDeg + FullDeg - 1) / FullDeg) * FullDeg;
      else if (x < -HalfDeg) x += ((-HalfDeg - x + FullDeg - 1) / FullDeg) * FullDeg;
      return x;
    endfunction

    // one filter step for an accepted sample transaction
    function void note_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                              logic [15:0] ms);
      longint qa, qb, rm, dt, p00, p01, p10, p11, n00, n01, n10, n11;
      longint inner, dp11, s, y, ang;
      qa = longint'(noise_angle) <<< 8;
      qb = longint'(noise_bias) <<< 8;
      rm = longint'(noise_meas) <<< 8;
      dt = ms;
      p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
      // prediction
      ang = clip32(angle_est + scaled_quot(longint'(gyro) - bias_est, dt, 1000));
      dp11 = scaled_quot(p11, dt, 1000);
      inner = clip48(dp11 - p01 - p10 + qa);
      n00 = clip48(p00 + scaled_quot(inner, dt, 1000));
      n01 = clip48(p01 - dp11);
      n10 = clip48(p10 - dp11);
      n11 = clip48(p11 + scaled_quot(qb, dt, 1000));
      // correction, skipped when the innovation variance is not positive
      s = n00 + rm;
      y = wrap_angle(longint'(meas) - ang);
      if (s > 0) begin
        ang = clip32(ang + scaled_quot(n00, y, s));
        bias_est = clip32(bias_est + scaled_quot(n10, y, s));
        cov[0] = clip48(n00 - scaled_quot(n00, n00, s));
        cov[1] = clip48(n01 - scaled_quot(n00, n01, s));
        cov[2] = clip48(n10 - scaled_quot(n10, n00, s));
        cov[3] = clip48(n11 - scaled_quot(n10, n01, s));
      end else begin
        cov[0] = n00; cov[1] = n01; cov[2] = n10; cov[3] = n11;
      end
      angle_est = wrap_angle(ang);
      angle_q.push_back(angle_est[24:0]);
    endfunction

    function void check_angle(logic signed [24:0] got);
      logic signed [24:0] want;
      if (angle_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected filtered angle %0d", got);
        return;
      end
      want = angle_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("filtered_angle mismatch: expected %0d actual %0d", want, got);
      end
    endfunction

    function int pending();
      return angle_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  agbk_in_if  in_ch ();
  agbk_out_if out_ch ();

  angle_gyro_bias_kalman DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  kalman_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // transaction monitor and idle watchdog, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.measured_angle, in_ch.gyro_rate, in_ch.elapsed_ms);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_angle(out_ch.filtered_angle);
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // register write: setup then access phase; register taken on the access edge
  task automatic cfg_write(agbk_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // one sample transaction; valid stays high afterwards until the next call
  task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                             logic [15:0] ms);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.measured_angle = meas;
    in_ch.gyro_rate = gyro;
    in_ch.elapsed_ms = ms;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // let every filtered angle come back, then a short settling gap
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [31:0] deg(int d);
    return d * 65536;
  endfunction

  // random sample: mostly plausible motion, sometimes raw full-range noise
  task automatic send_random();
    logic signed [31:0] meas, gyro;
    logic [15:0] ms;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 80) begin
      meas = $signed($urandom_range(2 * 230 * 65536)) - 230 * 65536;
      gyro = $signed($urandom_range(2 * 500 * 65536)) - 500 * 65536;
      ms   = 16'($urandom_range(1, 50));
    end else if (kind < 90) begin
      meas = $urandom();
      gyro = $urandom();
      ms   = 16'($urandom());
    end else begin
      meas = $urandom();
      gyro = $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
      ms   = 16'($urandom_range(0, 1000));
    end
    send_sample(meas, gyro, ms);
  endtask

  initial begin
    int unsigned phase_len;
    in_ch.valid = 1'b0;
    in_ch.measured_angle = '0;
    in_ch.gyro_rate = '0;
    in_ch.elapsed_ms = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset noise settings first
    send_sample(deg(10), deg(0), 16'd10);
    send_sample(deg(180), deg(5), 16'd0);               // zero time step, +180 kept
    send_sample(-deg(180), -deg(5), 16'd1);
    send_sample(deg(500), deg(90), 16'd20);             // innovation wraps
    send_sample(-deg(700), deg(0), 16'd20);
    send_sample(32'sh7fffffff, 32'sh7fffffff, 16'hffff); // extremes, angle saturates
    send_sample(32'sh80000000, 32'sh80000000, 16'hffff);
    send_sample(32'sh7fffffff, 32'sh80000000, 16'd1);
    send_sample('0, '0, 16'd0);
    drain();

    // extreme noise settings, unknown register ignored
    cfg_write(agbk_pkg::REG_Q_ANGLE, 32'hffffffff);
    cfg_write(agbk_pkg::REG_Q_BIAS, 32'hffffffff);
    cfg_write(agbk_pkg::REG_R_MEAS, 32'd1);
    cfg_write(agbk_pkg::REG_NONE, 32'hdeadbeef);
    send_sample(deg(45), deg(30), 16'd100);
    send_sample(-deg(170), -deg(300), 16'hffff);
    send_sample(deg(179), deg(1), 16'd5);
    send_sample(32'sh80000000, 32'sh7fffffff, 16'hffff);
    send_sample(deg(0), deg(0), 16'd0);
    drain();

    cfg_write(agbk_pkg::REG_Q_ANGLE, 32'd0);
    cfg_write(agbk_pkg::REG_Q_BIAS, 32'd0);
    cfg_write(agbk_pkg::REG_R_MEAS, 32'hffffffff);
    send_sample(deg(90), deg(10), 16'd10);
    send_sample(-deg(90), -deg(10), 16'hffff);
    send_sample(deg(360), deg(0), 16'd0);
    drain();

    // random phases: idle pattern and noise settings change between them
    phase_len = RandomItems / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph == 4) begin
        cfg_write(agbk_pkg::REG_Q_ANGLE, agbk_pkg::QAngleRst);
        cfg_write(agbk_pkg::REG_Q_BIAS, agbk_pkg::QBiasRst);
        cfg_write(agbk_pkg::REG_R_MEAS, agbk_pkg::RMeasRst);
      end else if (ph != 0) begin
        cfg_write(agbk_pkg::REG_Q_ANGLE, $urandom_range(0, 32'h00ffffff));
        cfg_write(agbk_pkg::REG_Q_BIAS, $urandom_range(0, 32'h000fffff));
        cfg_write(agbk_pkg::REG_R_MEAS, ph == 7 ? $urandom_range(1, 32'hffffffff)
                                                : $urandom_range(1, 32'h0fffffff));
      end
      for (int i = 0; i < phase_len; i++) begin
        send_random();
        // hold off once until the pipeline is empty
        if (ph == 3 && i == phase_len / 2) begin
          @(negedge clk);
          in_ch.valid = 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DrainCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/agbk_pkg.sv
src/agbk_if.sv
src/agbk_cfg.sv
src/agbk_muldiv.sv
src/angle_gyro_bias_kalman.sv
verif/tb.sv
